// ===== hdl/slr_pkg.sv =====
`default_nettype none

package slr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int RATE_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int WIDE_W    = 64;
  localparam int HALF_W    = WIDE_W / 2;

  // Signed multiplier: a carries a sample, a sample difference or a rate,
  // b carries one 32-bit half of a wide operand or the output rate.
  localparam int MUL_A_W = RATE_W + 1;
  localparam int MUL_P_W = MUL_A_W + HALF_W + 1;

  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES         = WIDE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

  localparam int NUM_LANES = 2;
  localparam int LANE_L    = 0;
  localparam int LANE_R    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = CFG_IDX_W'(1);

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = RATE_W'(44100);
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = RATE_W'(48000);

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LIM_LO,
    MUL_LIM_HI,
    MUL_BASE,
    MUL_FRAC_LO,
    MUL_FRAC_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    LIM_HOLD,
    LIM_SET,
    LIM_ADD_HI
  } lim_op_t;

  typedef struct packed {
    logic    capture;
    logic    bump_idx;
    mul_op_t mul_op;
    acc_op_t acc_op;
    lim_op_t lim_op;
    logic    frac_load;
    logic    n_clear;
    logic    div_start;
    logic    div_step;
    logic    advance;
    logic    pos_init;
    logic    prev_load;
    logic    out_load;
    logic    out_pass;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic pos_le_limit;
    logic n_full;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/slr_div.sv =====
`default_nettype none

module slr_div import slr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                start,
  input  wire logic                step,
  input  wire logic [WIDE_W-1:0]   dividend,
  input  wire logic [RATE_W-1:0]   divisor,
  output logic      [SAMPLE_W-1:0] quotient
);

  logic [WIDE_W-1:0]   dvd_r, dvd_nxt;
  logic [RATE_W-1:0]   rem_r, rem_nxt;
  logic [SAMPLE_W-1:0] quo_r, quo_nxt;
  logic                neg_r, neg_nxt;

  // Restoring division of the magnitude. Only the low quotient bits are kept;
  // the high ones only shape the running remainder.
  always_comb begin
    logic [RATE_W:0] trial;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    neg_nxt = neg_r;
    trial   = '0;
    if (start) begin
      neg_nxt = dividend[WIDE_W-1];
      dvd_nxt = dividend[WIDE_W-1] ? (~dividend + WIDE_W'(1)) : dividend;
      rem_nxt = '0;
      quo_nxt = '0;
    end else if (step) begin
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
        trial   = {rem_nxt, dvd_nxt[WIDE_W-1]};
        dvd_nxt = {dvd_nxt[WIDE_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = RATE_W'(trial - {1'b0, divisor});
          quo_nxt = {quo_nxt[SAMPLE_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[RATE_W-1:0];
          quo_nxt = {quo_nxt[SAMPLE_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
  end

  // A zero divisor yields zero by definition.
  assign quotient = (divisor == '0) ? '0 :
                    (neg_r ? SAMPLE_W'(~quo_r + SAMPLE_W'(1)) : quo_r);

endmodule

`default_nettype wire

// ===== hdl/slr_dp.sv =====
`default_nettype none

module slr_dp import slr_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [RATE_W-1:0]          cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_right_sample,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic signed [SAMPLE_W-1:0]      out_left_out,
  output logic signed [SAMPLE_W-1:0]      out_right_out,
  output logic                            out_last_of_run,
  input  wire cmd_t                       cmd,
  output status_t                         status
);

  logic [RATE_W-1:0] src_rate_r, out_rate_r;
  logic [WIDE_W-1:0] idx_r, idx_nxt;
  logic [WIDE_W-1:0] pos_r, pos_nxt;
  logic [WIDE_W-1:0] limit_r, limit_nxt;
  logic [WIDE_W-1:0] frac_r, frac_nxt;
  logic [WIDE_W-1:0] seg_start;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r;

  logic signed [SAMPLE_W-1:0] in_smp   [NUM_LANES];
  logic signed [SAMPLE_W-1:0] cur_r    [NUM_LANES];
  logic signed [SAMPLE_W-1:0] prev_r   [NUM_LANES];
  logic signed [SAMPLE_W-1:0] out_smp_r[NUM_LANES];
  logic signed [DIFF_W-1:0]   diff     [NUM_LANES];
  logic signed [MUL_A_W-1:0]  mul_a    [NUM_LANES];
  logic        [HALF_W-1:0]   mul_b    [NUM_LANES];
  logic signed [MUL_P_W-1:0]  prod_nxt [NUM_LANES];
  logic signed [MUL_P_W-1:0]  prod_r   [NUM_LANES];
  logic        [WIDE_W-1:0]   acc_r    [NUM_LANES];
  logic        [WIDE_W-1:0]   acc_nxt  [NUM_LANES];
  logic        [SAMPLE_W-1:0] quo      [NUM_LANES];

  assign in_smp[LANE_L] = in_left_sample;
  assign in_smp[LANE_R] = in_right_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rate_r <= SOURCE_RATE_RST;
      out_rate_r <= OUTPUT_RATE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SOURCE_RATE) begin
        src_rate_r <= cfg_data;
      end
      if (cfg_index == REG_OUTPUT_RATE) begin
        out_rate_r <= cfg_data;
      end
    end
  end

  // The weighted sum is rewritten as prev*rate + (cur - prev)*frac, which
  // equals the two-term form modulo 2^64.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      diff[i] = DIFF_W'(cur_r[i]) - DIFF_W'(prev_r[i]);
      unique case (cmd.mul_op)
        MUL_LIM_LO: begin
          mul_a[i] = {1'b0, out_rate_r};
          mul_b[i] = idx_r[HALF_W-1:0];
        end
        MUL_LIM_HI: begin
          mul_a[i] = {1'b0, out_rate_r};
          mul_b[i] = idx_r[WIDE_W-1:HALF_W];
        end
        MUL_BASE: begin
          mul_a[i] = MUL_A_W'(prev_r[i]);
          mul_b[i] = HALF_W'(out_rate_r);
        end
        MUL_FRAC_LO: begin
          mul_a[i] = MUL_A_W'(diff[i]);
          mul_b[i] = frac_r[HALF_W-1:0];
        end
        MUL_FRAC_HI: begin
          mul_a[i] = MUL_A_W'(diff[i]);
          mul_b[i] = frac_r[WIDE_W-1:HALF_W];
        end
        default: begin
          mul_a[i] = '0;
          mul_b[i] = '0;
        end
      endcase
      prod_nxt[i] = MUL_P_W'(mul_a[i]) * MUL_P_W'($signed({1'b0, mul_b[i]}));

      unique case (cmd.acc_op)
        ACC_HOLD:   acc_nxt[i] = acc_r[i];
        ACC_SET:    acc_nxt[i] = WIDE_W'(prod_r[i]);
        ACC_ADD:    acc_nxt[i] = acc_r[i] + WIDE_W'(prod_r[i]);
        ACC_ADD_HI: acc_nxt[i] = acc_r[i] + {prod_r[i][HALF_W-1:0], HALF_W'(0)};
        default:    acc_nxt[i] = acc_r[i];
      endcase
    end
  end

  assign seg_start = limit_r - WIDE_W'(out_rate_r);

  always_comb begin
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    limit_nxt = limit_r;
    frac_nxt  = frac_r;
    n_nxt     = n_r;
    if (cmd.bump_idx) begin
      idx_nxt = idx_r + WIDE_W'(1);
    end
    unique case (cmd.lim_op)
      LIM_HOLD:   limit_nxt = limit_r;
      LIM_SET:    limit_nxt = WIDE_W'(prod_r[LANE_L]);
      LIM_ADD_HI: limit_nxt = limit_r + {prod_r[LANE_L][HALF_W-1:0], HALF_W'(0)};
      default:    limit_nxt = limit_r;
    endcase
    if (cmd.frac_load) begin
      frac_nxt = pos_r - seg_start;
    end
    if (cmd.pos_init) begin
      pos_nxt = WIDE_W'(src_rate_r);
    end else if (cmd.advance) begin
      pos_nxt = pos_r + WIDE_W'(src_rate_r);
    end
    if (cmd.n_clear) begin
      n_nxt = '0;
    end else if (cmd.advance) begin
      n_nxt = n_r + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pos_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    frac_r  <= frac_nxt;
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_r[i] <= prod_nxt[i];
      acc_r[i]  <= acc_nxt[i];
      if (cmd.capture) begin
        cur_r[i] <= in_smp[i];
      end
      if (cmd.prev_load) begin
        prev_r[i] <= cur_r[i];
      end
      if (cmd.out_load) begin
        out_smp_r[i] <= cmd.out_pass ? cur_r[i] : $signed(quo[i]);
      end
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    slr_div u_div (
      .clk      (clk),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (acc_r[g]),
      .divisor  (out_rate_r),
      .quotient (quo[g])
    );
  end

  assign status.pos_le_limit = (pos_r <= limit_r);
  assign status.n_full       = (n_r == CNT_W'(MAX_RESULTS));
  assign status.out_free     = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_left_out    = out_smp_r[LANE_L];
  assign out_right_out   = out_smp_r[LANE_R];
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/slr_ctrl.sv =====
`default_nettype none

module slr_ctrl import slr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = ST_W'(0);
  localparam logic [ST_W-1:0] S_FIRST   = ST_W'(1);
  localparam logic [ST_W-1:0] S_LIM0    = ST_W'(2);
  localparam logic [ST_W-1:0] S_LIM1    = ST_W'(3);
  localparam logic [ST_W-1:0] S_LIM2    = ST_W'(4);
  localparam logic [ST_W-1:0] S_CHECK   = ST_W'(5);
  localparam logic [ST_W-1:0] S_MUL0    = ST_W'(6);
  localparam logic [ST_W-1:0] S_MUL1    = ST_W'(7);
  localparam logic [ST_W-1:0] S_MUL2    = ST_W'(8);
  localparam logic [ST_W-1:0] S_MUL3    = ST_W'(9);
  localparam logic [ST_W-1:0] S_DIVINIT = ST_W'(10);
  localparam logic [ST_W-1:0] S_DIV     = ST_W'(11);
  localparam logic [ST_W-1:0] S_ADV     = ST_W'(12);
  localparam logic [ST_W-1:0] S_EMIT    = ST_W'(13);

  logic [ST_W-1:0]      state_r, state_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 more;

  // Another result follows if the advanced position is still inside the
  // segment and the per-frame result budget is not spent.
  assign more = status.pos_le_limit && !status.n_full;

  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    div_cnt_nxt   = div_cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (have_prev_r) begin
            cmd.bump_idx = 1'b1;
            state_nxt    = S_LIM0;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_pass  = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.prev_load = 1'b1;
          cmd.pos_init  = 1'b1;
          have_prev_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LIM0: begin
        cmd.mul_op = MUL_LIM_LO;
        state_nxt  = S_LIM1;
      end
      S_LIM1: begin
        cmd.mul_op = MUL_LIM_HI;
        cmd.lim_op = LIM_SET;
        state_nxt  = S_LIM2;
      end
      S_LIM2: begin
        cmd.lim_op  = LIM_ADD_HI;
        cmd.n_clear = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (status.pos_le_limit) begin
          cmd.frac_load = 1'b1;
          state_nxt     = S_MUL0;
        end else begin
          cmd.prev_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL0: begin
        cmd.mul_op = MUL_BASE;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_op = MUL_FRAC_LO;
        cmd.acc_op = ACC_SET;
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_op = MUL_FRAC_HI;
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_op = ACC_ADD_HI;
        state_nxt  = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_start = 1'b1;
        div_cnt_nxt   = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !more;
          if (more) begin
            cmd.frac_load = 1'b1;
            state_nxt     = S_MUL0;
          end else begin
            cmd.prev_load = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten while held");

  // A frame that follows the first one always starts the segment setup.
  a_seg_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && have_prev_r) |=> (state_r == S_LIM0))
    else $error("accepted frame did not start the segment setup");

  // A result not marked last is always followed by another computation.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_last) |=> (state_r == S_MUL0))
    else $error("run ended without a last marker");

endmodule

`default_nettype wire

// ===== hdl/stereo_linear_resampler_unit.sv =====
`default_nettype none

// Stereo linear-interpolation sample rate converter. Each accepted input frame
// gives zero or more output frames; last_of_run marks the final one a frame
// caused. The first frame after reset is passed straight through. Every later
// frame first finds its segment (the index times output_rate product, built
// from 32-bit halves on the left lane's multiplier) and then, per output frame,
// runs the multiply/accumulate steps on both channels at once and then the
// divider, which resolves two quotient bits a cycle over the 64-bit weighted
// sum. One frame is processed at a time; the output register lets the next
// frame be taken while the final result still waits downstream. Registers are
// to be written only while idle; the block itself does not enforce this.
module stereo_linear_resampler_unit import slr_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [RATE_W-1:0]          cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_left_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_right_sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_left_out,
  output logic signed [SAMPLE_W-1:0]      out_right_out,
  output logic                            out_last_of_run
);

  cmd_t    cmd;
  status_t status;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

`default_nettype wire
